/* design/glos_pkg.sv */
package glos_pkg;

  localparam int GRID_SIZE = 512;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WADDR_W   = COORD_W + COORD_W - BIT_W;
  localparam int MAP_WORDS = GRID_SIZE * GRID_SIZE / WORD_W;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;
  localparam logic [7:0] OCC_VALUE = 8'hFF;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic [WADDR_W-1:0] raddr;
  } map_req_t;

endpackage

/* design/glos_map.sv */
module glos_map (
  input  logic                     clk,
  input  glos_pkg::map_req_t       req,
  output logic [glos_pkg::WORD_W-1:0] rd_data
);
  import glos_pkg::*;

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/grid_line_of_sight_check_unit.sv */
// channel  dir  handshake            payload
// in_      in   in_valid/in_stall    in_cmd in_ax in_ay in_bx in_by in_cell_value
// out_     out  out_valid/out_stall  out_path_clear (one word per query)
//
// after reset the map is cleared one 64-bit word a cycle, with in_stall high
// write word: accepted with the read of its map word, then written back in ST_WR_WB
// query word: accept, 9 divider steps, a setup state (both skipped when vertical), then one
//   map bit per cycle through the single read port, then finish; equal points go to finish
// a finished result sits in the output register while the next word is accepted
// a result waits in the finish state while out_stall holds a full output register
module grid_line_of_sight_check_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [glos_pkg::COORD_W-1:0]  in_ax,
  input  logic [glos_pkg::COORD_W-1:0]  in_ay,
  input  logic [glos_pkg::COORD_W-1:0]  in_bx,
  input  logic [glos_pkg::COORD_W-1:0]  in_by,
  input  logic signed [7:0]             in_cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_path_clear
);
  import glos_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WR_WB = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DSET  = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam int DCNT_W = $clog2(COORD_W);

  logic [2:0]         state_r;
  logic [WADDR_W-1:0] clr_cnt_r;
  logic [WADDR_W-1:0] waddr_r;
  logic [BIT_W-1:0]   bitsel_r;
  logic               occ_r;
  logic               res_r;
  logic               out_valid_r;
  logic               out_path_clear_r;

  logic [COORD_W-1:0] x_r, y_r, q_r, cnt_r;
  logic [COORD_W:0]   r_r, rr_r, d2_r;
  logic               xinc_r, pend_r, dneg_r;
  logic [COORD_W-1:0] div_rem_r, div_quo_r;
  logic [DCNT_W-1:0]  div_cnt_r;

  logic [WORD_W-1:0]  rd_data;
  map_req_t           map_req;

  // walk step
  logic [COORD_W+1:0] rsum;
  logic               carry;
  logic [COORD_W:0]   r_nxt;
  logic [COORD_W-1:0] y_nxt, x_nxt;

  // query setup
  logic               accept, same_pt, vert, swap, dy_neg;
  logic [COORD_W-1:0] sx, sy, ex, ey, dx, ady, lo, hi;

  // divider step
  logic [COORD_W:0]   div_sh;
  logic               div_ge;
  logic [COORD_W-1:0] div_rem_nxt;

  logic               out_free, out_load, hit;
  logic [WORD_W-1:0]  wmask;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && out_free;
  assign hit      = pend_r && rd_data[bitsel_r];
  assign wmask    = WORD_W'(1) << bitsel_r;

  assign rsum  = {1'b0, r_r} + {1'b0, rr_r};
  assign carry = (rsum >= {1'b0, d2_r});
  assign r_nxt = carry ? (COORD_W+1)'(rsum - {1'b0, d2_r}) : rsum[COORD_W:0];
  assign y_nxt = y_r + q_r + COORD_W'(carry);
  assign x_nxt = x_r + COORD_W'(xinc_r);

  assign same_pt = (in_ax == in_bx) && (in_ay == in_by);
  assign vert    = (in_ax == in_bx);
  assign swap    = (in_bx < in_ax);
  assign sx      = swap ? in_bx : in_ax;
  assign sy      = swap ? in_by : in_ay;
  assign ex      = swap ? in_ax : in_bx;
  assign ey      = swap ? in_ay : in_by;
  assign dx      = ex - sx;
  assign dy_neg  = (ey < sy);
  assign ady     = dy_neg ? (sy - ey) : (ey - sy);
  assign lo      = (in_ay < in_by) ? in_ay : in_by;
  assign hi      = (in_ay < in_by) ? in_by : in_ay;

  assign div_sh      = {div_rem_r, div_quo_r[COORD_W-1]};
  assign div_ge      = (div_sh >= {1'b0, d2_r[COORD_W:1]});
  assign div_rem_nxt = div_ge ? COORD_W'(div_sh - {1'b0, d2_r[COORD_W:1]})
                              : div_sh[COORD_W-1:0];

  always_comb begin
    map_req.we    = 1'b0;
    map_req.waddr = waddr_r;
    map_req.wdata = occ_r ? (rd_data | wmask) : (rd_data & ~wmask);
    map_req.raddr = {in_ay, in_ax[COORD_W-1:BIT_W]};
    unique case (state_r)
      ST_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_cnt_r;
        map_req.wdata = '0;
      end
      ST_WR_WB: begin
        map_req.we = 1'b1;
      end
      ST_WALK: begin
        map_req.raddr = {y_nxt, x_nxt[COORD_W-1:BIT_W]};
      end
      default: begin
      end
    endcase
  end

  glos_map u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r      <= 1'b1;
        out_path_clear_r <= res_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + WADDR_W'(1);
          if (clr_cnt_r == WADDR_W'(MAP_WORDS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            pend_r <= 1'b0;
            if (in_cmd == CMD_WRITE) begin
              waddr_r  <= {in_ay, in_ax[COORD_W-1:BIT_W]};
              bitsel_r <= in_ax[BIT_W-1:0];
              occ_r    <= (in_cell_value == OCC_VALUE);
              state_r  <= ST_WR_WB;
            end else if (same_pt) begin
              res_r   <= 1'b0;
              state_r <= ST_FIN;
            end else if (vert) begin
              x_r     <= in_ax;
              xinc_r  <= 1'b0;
              y_r     <= lo - COORD_W'(1);
              q_r     <= COORD_W'(1);
              rr_r    <= '0;
              r_r     <= '0;
              d2_r    <= (COORD_W+1)'(1);
              cnt_r   <= hi - lo;
              state_r <= ST_WALK;
            end else begin
              x_r       <= sx;
              xinc_r    <= 1'b1;
              y_r       <= sy;
              r_r       <= {1'b0, dx};
              d2_r      <= {dx, 1'b0};
              cnt_r     <= dx - COORD_W'(1);
              dneg_r    <= dy_neg;
              div_rem_r <= '0;
              div_quo_r <= ady;
              div_cnt_r <= '0;
              state_r   <= ST_DIV;
            end
          end
        end
        ST_WR_WB: begin
          state_r <= ST_IDLE;
        end
        ST_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= {div_quo_r[COORD_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(COORD_W - 1)) begin
            state_r <= ST_DSET;
          end
        end
        ST_DSET: begin
          // floor step of 2*dy over 2*dx
          priority if (!dneg_r) begin
            q_r  <= div_quo_r;
            rr_r <= {div_rem_r, 1'b0};
          end else if (div_rem_r == '0) begin
            q_r  <= COORD_W'(0) - div_quo_r;
            rr_r <= '0;
          end else begin
            q_r  <= ~div_quo_r;
            rr_r <= {d2_r[COORD_W:1] - div_rem_r, 1'b0};
          end
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          priority if (hit) begin
            res_r   <= 1'b0;
            state_r <= ST_FIN;
          end else if (cnt_r != '0) begin
            x_r      <= x_nxt;
            y_r      <= y_nxt;
            r_r      <= r_nxt;
            bitsel_r <= x_nxt[BIT_W-1:0];
            cnt_r    <= cnt_r - COORD_W'(1);
            pend_r   <= 1'b1;
          end else begin
            res_r   <= 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_path_clear = out_path_clear_r;

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FIN)
    else $error("result word raised outside finish");

  a_wb_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR_WB || state_r == ST_CLEAR) |-> map_req.we)
    else $error("map write missing");

  a_same_point: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_QUERY && in_ax == in_bx && in_ay == in_by)
      |=> (state_r == ST_FIN && !res_r))
    else $error("equal points not reported blocked");

  a_walk_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && hit) |=> (state_r == ST_FIN && !res_r))
    else $error("occupied cell missed");

endmodule

/* tb/glos_checker.sv */
`timescale 1ns / 1ps

module glos_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [glos_pkg::COORD_W-1:0] in_ax,
  input  logic [glos_pkg::COORD_W-1:0] in_ay,
  input  logic [glos_pkg::COORD_W-1:0] in_bx,
  input  logic [glos_pkg::COORD_W-1:0] in_by,
  input  logic [7:0]                   in_cell_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_path_clear,
  output int                           errors,
  output int                           outstanding,
  output int                           n_writes,
  output int                           n_clear,
  output int                           n_blocked
);
  import glos_pkg::*;

  localparam int PEND_DEPTH = 16;

  bit occ_map [GRID_SIZE*GRID_SIZE];
  bit pend_fifo [PEND_DEPTH];
  int pend_wr;
  int pend_rd;
  bit want;

  function automatic bit occupied(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_SIZE || y >= GRID_SIZE) return 1'b0;
    return occ_map[y*GRID_SIZE + x];
  endfunction

  function automatic bit segment_is_free(int ax, int ay, int bx, int by);
    int sx, sy, dx, dy, lo, hi, row;
    if (ax == bx) begin
      if (ay == by) return 1'b0;
      lo = (ay < by) ? ay : by;
      hi = (ay < by) ? by : ay;
      for (int r = lo; r < hi; r++)
        if (occupied(ax, r)) return 1'b0;
      return 1'b1;
    end
    if (ax < bx) begin
      sx = ax; sy = ay; dx = bx - ax; dy = by - ay;
    end else begin
      sx = bx; sy = by; dx = ax - bx; dy = ay - by;
    end
    // exact row of each interior column, halves rounded up
    for (int i = 1; i < dx; i++) begin
      row = (2*(sy*dx + i*dy) + dx) / (2*dx);
      if (occupied(sx + i, row)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string what);
    $display("%0t checker: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pend_wr == pend_rd) begin
          report($sformatf("path_clear word %0b with no query pending", out_path_clear));
        end else begin
          want = pend_fifo[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (out_path_clear !== want)
            report($sformatf("path_clear got %0b want %0b", out_path_clear, want));
        end
        if (out_path_clear === 1'b1) n_clear++;
        else n_blocked++;
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_WRITE) begin
          occ_map[int'(in_ay)*GRID_SIZE + int'(in_ax)] = (in_cell_value == OCC_VALUE);
          n_writes++;
        end else if (pend_wr - pend_rd >= PEND_DEPTH) begin
          report("too many queries pending");
        end else begin
          pend_fifo[pend_wr % PEND_DEPTH] =
            segment_is_free(int'(in_ax), int'(in_ay), int'(in_bx), int'(in_by));
          pend_wr++;
        end
      end
      outstanding = pend_wr - pend_rd;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import glos_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_WORDS = 1150;
  localparam int TAIL_CYCLES  = 600;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [COORD_W-1:0] in_ax;
  logic [COORD_W-1:0] in_ay;
  logic [COORD_W-1:0] in_bx;
  logic [COORD_W-1:0] in_by;
  logic [7:0]         in_cell_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_path_clear;

  int errors, outstanding, n_writes, n_clear, n_blocked;
  int idle_cycles = 0;
  bit hold_done;
  int win_x, win_y, win_w;

  grid_line_of_sight_check_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_ax          (in_ax),
    .in_ay          (in_ay),
    .in_bx          (in_bx),
    .in_by          (in_by),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_path_clear (out_path_clear)
  );

  glos_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_ax          (in_ax),
    .in_ay          (in_ay),
    .in_bx          (in_bx),
    .in_by          (in_by),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_path_clear (out_path_clear),
    .errors         (errors),
    .outstanding    (outstanding),
    .n_writes       (n_writes),
    .n_clear        (n_clear),
    .n_blocked      (n_blocked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 250);
  endfunction

  task automatic send_word(input logic c, input logic [COORD_W-1:0] ax,
                           input logic [COORD_W-1:0] ay,
                           input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                           input logic [7:0] cv, input int gap);
    @(negedge clk);
    in_valid      = 1'b1;
    in_cmd        = c;
    in_ax         = ax;
    in_ay         = ay;
    in_bx         = bx;
    in_by         = by;
    in_cell_value = cv;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic pick_window();
    int r;
    r = $urandom_range(0, 9);
    win_w = (r < 2) ? 4 : (r < 5) ? 8 : (r < 7) ? 16 : (r < 9) ? 32 : 64;
    if ($urandom_range(0, 19) == 0) win_w = GRID_SIZE;
    win_x = $urandom_range(0, GRID_SIZE - win_w);
    win_y = $urandom_range(0, GRID_SIZE - win_w);
  endtask

  // mostly writes and queries packed into one small window so that they interact
  task automatic random_word(input int gap);
    int r;
    logic c;
    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [7:0] cv;
    r  = $urandom_range(0, 99);
    ax = COORD_W'(win_x + $urandom_range(0, win_w - 1));
    ay = COORD_W'(win_y + $urandom_range(0, win_w - 1));
    bx = COORD_W'(win_x + $urandom_range(0, win_w - 1));
    by = COORD_W'(win_y + $urandom_range(0, win_w - 1));
    cv = ($urandom_range(0, 2) != 0) ? OCC_VALUE : 8'($urandom);
    c  = (r < 45) ? CMD_WRITE : CMD_QUERY;
    if (r >= 45 && r < 55) begin
      bx = ax;
    end else if (r >= 55 && r < 62) begin
      by = ay;
    end else if (r >= 62 && r < 65) begin
      bx = ax;
      by = ay;
    end else if (r >= 88) begin
      c  = 1'($urandom);
      ax = COORD_W'($urandom);
      ay = COORD_W'($urandom);
      bx = COORD_W'($urandom);
      by = COORD_W'($urandom);
      cv = 8'($urandom);
    end
    send_word(c, ax, ay, bx, by, cv, gap);
  endtask

  // result side: random stall, one long hold-off once output has been flowing
  initial begin
    int stall_len, free_len;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if (!hold_done && n_clear + n_blocked >= 100) begin
        hold_done = 1'b1;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = gap_len();
      end
      free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : gap_len();
      if (stall_len > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (stall_len - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      repeat (free_len) @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_WRITE;
    in_ax         = '0;
    in_ay         = '0;
    in_bx         = '0;
    in_by         = '0;
    in_cell_value = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_word(CMD_QUERY, 9'd0,   9'd0,   9'd511, 9'd511, 8'h00, 0);
    send_word(CMD_QUERY, 9'd7,   9'd7,   9'd7,   9'd7,   8'h00, 0);
    send_word(CMD_WRITE, 9'd0,   9'd0,   9'd0,   9'd0,   OCC_VALUE, 0);
    send_word(CMD_WRITE, 9'd511, 9'd511, 9'd511, 9'd511, OCC_VALUE, 2);
    send_word(CMD_QUERY, 9'd0,   9'd0,   9'd511, 9'd511, 8'h00, 0);
    send_word(CMD_QUERY, 9'd0,   9'd0,   9'd0,   9'd5,   8'h00, 0);
    send_word(CMD_QUERY, 9'd511, 9'd511, 9'd511, 9'd200, 8'h00, 0);
    send_word(CMD_WRITE, 9'd1,   9'd1,   9'd0,   9'd0,   OCC_VALUE, 0);
    send_word(CMD_QUERY, 9'd0,   9'd0,   9'd2,   9'd1,   8'h00, 0);
    send_word(CMD_QUERY, 9'd2,   9'd1,   9'd0,   9'd0,   8'h00, 3);
    send_word(CMD_WRITE, 9'd1,   9'd1,   9'd0,   9'd0,   8'h00, 0);
    send_word(CMD_QUERY, 9'd0,   9'd0,   9'd2,   9'd1,   8'h00, 0);
    send_word(CMD_WRITE, 9'd1,   9'd1,   9'd0,   9'd0,   8'h7F, 0);
    send_word(CMD_WRITE, 9'd1,   9'd1,   9'd0,   9'd0,   8'h80, 0);
    send_word(CMD_QUERY, 9'd0,   9'd2,   9'd2,   9'd0,   8'h00, 0);
    send_word(CMD_WRITE, 9'd1,   9'd1,   9'd0,   9'd0,   OCC_VALUE, 0);
    send_word(CMD_QUERY, 9'd0,   9'd2,   9'd2,   9'd0,   8'h00, 0);
    send_word(CMD_WRITE, 9'd300, 9'd100, 9'd0,   9'd0,   OCC_VALUE, 0);
    send_word(CMD_QUERY, 9'd299, 9'd100, 9'd301, 9'd100, 8'h00, 0);
    send_word(CMD_QUERY, 9'd300, 9'd101, 9'd300, 9'd99,  8'h00, 0);
    send_word(CMD_QUERY, 9'd300, 9'd0,   9'd301, 9'd511, 8'h00, 0);
    send_word(CMD_WRITE, 9'd511, 9'd511, 9'd0,   9'd0,   8'hFE, 0);
    send_word(CMD_QUERY, 9'd511, 9'd0,   9'd0,   9'd511, 8'h00, 0);
    drain();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 40 == 0) pick_window();
      if (k == RANDOM_WORDS / 2) drain();
      random_word(((k % 150) < 40) ? 0 : gap_len());
    end
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("testbench summary: %0d cell writes, %0d segment queries (%0d clear, %0d blocked)",
             n_writes, n_clear + n_blocked, n_clear, n_blocked);
    $display("testbench summary: output held off %0d cycles once (%0s), input drained twice mid-run",
             HOLD_CYCLES, hold_done ? "done" : "not reached");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* grid_line_of_sight_check_unit.f */
design/glos_pkg.sv
design/glos_map.sv
design/grid_line_of_sight_check_unit.sv
tb/glos_checker.sv
tb/testbench.sv
